// ===== hw/rtl/mkdt_pkg.sv =====
// Shared types and codes for the MAC-keyed access point table.
package mkdt_pkg;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_CLEARED  = 2'd3;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNTED_MODE   = 1'd1;

    localparam int KEY_W   = 48;
    localparam int MODE_W  = 4;
    localparam int NUM_MODES = 16;
    localparam logic [6:0] CAPACITY_RESET = 7'd64;

    typedef struct packed {
        logic                opcode;
        logic [KEY_W-1:0]    mac_key;
        logic signed [7:0]   signal_strength;
        logic [3:0]          radio_channel;
        logic [MODE_W-1:0]   security_mode;
        logic                name_empty;
        logic [31:0]         time_stamp;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] entry_index;
        logic [6:0] entry_count;
        logic [6:0] hidden_count;
        logic [6:0] mode_count;
    } out_item_t;

endpackage

// ===== hw/rtl/mkdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mkdt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/mac_keyed_dedup_table.sv =====
// Top level: MAC-keyed access point table with lookup, insert and clear.
// Flow: a clear goes straight to commit; an observe scans the stored keys in order, one key
//   compared per cycle, stops at the first hit, and on a miss inserts or drops the key.
// Throughput: one transaction at a time; the input is held until the result is committed,
//   and a result left waiting in the output register stalls both an observe and a clear.
// Reset: counters clear and config registers take defaults at once; key RAM stays undefined.
module mac_keyed_dedup_table
    import mkdt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Address, count and extended widths all follow the table depth.
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > 7) ? CW : 7;
    localparam int XW = (AW > 6) ? AW : 6;
    localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [6:0]        cap_reg;
    logic [MODE_W-1:0] cmode_reg;

    // Held fields of the transaction being worked on.
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [MODE_W-1:0] imode_reg, imode_next;
    logic              ihidden_reg, ihidden_next;

    logic [1:0]        status_reg, status_next;
    logic [AW-1:0]     index_reg, index_next;

    // Scan pointers: issue runs one entry ahead of compare (RAM read latency).
    logic [CW-1:0]     issue_reg, issue_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              cmp_valid_reg, cmp_valid_next;

    // Table occupancy and running summary counters.
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     hidden_reg, hidden_next;
    logic [CW-1:0]     hist_reg [NUM_MODES];
    logic [CW-1:0]     hist_next [NUM_MODES];

    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic [KEY_W-1:0]  rd_key;
    logic              load;
    logic              ram_we;
    logic [LW-1:0]     count_l, cap_l, limit_l;
    logic [XW-1:0]     index_x;
    logic [LW-1:0]     cnt_x, hid_x, mode_x;

    mkdt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (key_reg),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_data (rd_key)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Effective capacity is the smaller of the register and the table depth.
    assign count_l = LW'(count_reg);
    assign cap_l   = LW'(cap_reg);
    assign limit_l = (cap_l < DEPTH_L) ? cap_l : DEPTH_L;

    // Commit the result once the output register is free.
    assign load   = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    assign ram_we = load && (status_reg == ST_INSERTED);

    // Configuration writes: apply at once, no handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAPACITY_RESET;
            cmode_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAPACITY_LIMIT: cap_reg   <= cfg_data[6:0];
                CFG_COUNTED_MODE:   cmode_reg <= cfg_data[MODE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Sequencer: accept, scan the key RAM (observe only), decide, then commit.
    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        imode_next     = imode_reg;
        ihidden_next   = ihidden_reg;
        status_next    = status_reg;
        index_next     = index_reg;
        issue_next     = issue_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next       = in_data.mac_key;
                    imode_next     = in_data.security_mode;
                    ihidden_next   = in_data.name_empty;
                    issue_next     = '0;
                    cmp_valid_next = 1'b0;
                    if (in_data.opcode == OP_CLEAR)
                    begin
                        status_next = ST_CLEARED;
                        index_next  = '0;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (cmp_valid_reg && (rd_key == key_reg))
                begin
                    status_next = ST_UPDATED;
                    index_next  = cmp_idx_reg;
                    state_next  = S_FINISH;
                end
                else if (issue_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[AW-1:0];
                    issue_next     = CW'(issue_reg + 1'b1);
                end
                else if (cmp_valid_reg)
                begin
                    // Drain the last compare before deciding.
                    cmp_valid_next = 1'b0;
                end
                else
                begin
                    if (count_l < limit_l)
                    begin
                        status_next = ST_INSERTED;
                        index_next  = count_reg[AW-1:0];
                    end
                    else
                    begin
                        status_next = ST_DROPPED;
                        index_next  = '0;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Counters after this transaction, and the result built from them.
    always_comb
    begin
        count_next  = count_reg;
        hidden_next = hidden_reg;
        for (int m = 0; m < NUM_MODES; m++)
        begin
            hist_next[m] = hist_reg[m];
        end
        if (load)
        begin
            case (status_reg)
                ST_CLEARED:
                begin
                    count_next  = '0;
                    hidden_next = '0;
                    for (int m = 0; m < NUM_MODES; m++)
                    begin
                        hist_next[m] = '0;
                    end
                end
                ST_INSERTED:
                begin
                    count_next = CW'(count_reg + 1'b1);
                    if (ihidden_reg)
                    begin
                        hidden_next = CW'(hidden_reg + 1'b1);
                    end
                    hist_next[imode_reg] = CW'(hist_reg[imode_reg] + 1'b1);
                end
                default:
                begin
                end
            endcase
        end

        index_x = XW'(index_reg);
        cnt_x   = LW'(count_next);
        hid_x   = LW'(hidden_next);
        mode_x  = LW'(hist_next[cmode_reg]);

        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next        = 1'b1;
            out_next.status       = status_reg;
            out_next.entry_index  = index_x[5:0];
            out_next.entry_count  = cnt_x[6:0];
            out_next.hidden_count = hid_x[6:0];
            out_next.mode_count   = mode_x[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            hidden_reg    <= '0;
            for (int m = 0; m < NUM_MODES; m++)
            begin
                hist_reg[m] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            count_reg     <= count_next;
            hidden_reg    <= hidden_next;
            for (int m = 0; m < NUM_MODES; m++)
            begin
                hist_reg[m] <= hist_next[m];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        imode_reg   <= imode_next;
        ihidden_reg <= ihidden_next;
        status_reg  <= status_next;
        index_reg   <= index_next;
        issue_reg   <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
        out_reg     <= out_next;
    end

    // The table never holds more entries than it has rows.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // Hidden entries are a subset of the valid entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        hidden_reg <= count_reg)
        else $error("hidden count exceeds entry count");

    // A committed clear leaves the table empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && (status_reg == ST_CLEARED)) |=> (count_reg == '0) && (hidden_reg == '0))
        else $error("clear did not empty the table");

endmodule
